FILE: rtl/touch_zone_qualifier_macros.svh
// ----------------------------------------------------------------------------
// Touch zone qualifier assertion macros
// Concurrent assertion wrappers on clk_i; compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef TOUCH_ZONE_QUALIFIER_MACROS_SVH
`define TOUCH_ZONE_QUALIFIER_MACROS_SVH

`ifndef ASSERT_OFF
// checked outside reset only
`define TZQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked at every edge, reset included
`define TZQ_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define TZQ_ASSERT(name, prop, msg)
`define TZQ_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

FILE: rtl/tzq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch zone qualifier package
// Shared types, register codes and constants.
// ----------------------------------------------------------------------------
package tzq_pkg;

  localparam int unsigned ZONE_COUNT = 4;
  localparam int unsigned ZONE_W     = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [15:0] THRESHOLD_RESET  = 16'd42598;  // ~0.65 in Q0.16
  localparam logic [3:0]  DEBOUNCE_RESET   = 4'd2;
  localparam logic [15:0] LONG_PRESS_RESET = 16'd500;

  // repeat window: held mod 200 below 20
  localparam logic [7:0]  REPEAT_WINDOW_MS = 8'd20;
  // ceil(2^34 / 25): exact floor division of any 29-bit value by 25
  localparam logic [29:0] RECIP_25         = 30'd687194768;
  localparam int unsigned RECIP_SHIFT      = 34;

  typedef enum logic [0:0] {
    MODE_CAL    = 1'b0,
    MODE_SAMPLE = 1'b1
  } mode_e;

  typedef enum logic [0:0] {
    KIND_RELEASE = 1'b0,
    KIND_REPEAT  = 1'b1
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD  = 2'd0,
    CFG_DEBOUNCE   = 2'd1,
    CFG_LONG_PRESS = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] threshold_factor;
    logic [3:0]  debounce_len;
    logic [15:0] hold_limit;
  } cfg_t;

  typedef struct packed {
    logic [15:0] baseline;
    logic        pressed;
    logic [3:0]  agree_count;
    logic [31:0] press_start;
  } zone_state_t;

  typedef struct packed {
    logic        emit;
    kind_e       kind;
    logic [31:0] held_ms;
  } event_t;

endpackage

FILE: rtl/tzq_zone_bank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch zone qualifier zone bank
// Per-zone state registers: one read and one write port, same zone.
// ----------------------------------------------------------------------------
module tzq_zone_bank (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [tzq_pkg::ZONE_W-1:0] zone_i,
  input  logic                       zone_ok_i,
  input  logic                       wr_en_i,
  input  tzq_pkg::zone_state_t       wr_data_i,
  output tzq_pkg::zone_state_t       rd_data_o
);

  tzq_pkg::zone_state_t bank_q [tzq_pkg::ZONE_COUNT];

  assign rd_data_o = zone_ok_i ? bank_q[zone_i] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(tzq_pkg::ZONE_COUNT); i++) begin
        bank_q[i] <= '0;
      end
    end else if (wr_en_i && zone_ok_i) begin
      bank_q[zone_i] <= wr_data_i;
    end
  end

endmodule

FILE: rtl/tzq_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch zone qualifier evaluator
// Threshold, debounce, release / repeat events and baseline drift for one beat.
// ----------------------------------------------------------------------------
module tzq_eval (
  input  tzq_pkg::mode_e       mode_i,
  input  logic [15:0]          reading_i,
  input  logic [31:0]          now_ms_i,
  input  tzq_pkg::cfg_t        cfg_i,
  input  tzq_pkg::zone_state_t cur_i,
  output tzq_pkg::zone_state_t nxt_o,
  output tzq_pkg::event_t      event_o
);

  logic [31:0] thr_prod;
  logic [15:0] threshold;
  logic        touched;
  logic [3:0]  cnt_inc;
  logic        flip;
  logic [31:0] held;
  logic [28:0] held_div8;
  logic [58:0] recip_prod;
  logic [24:0] quot25;
  logic [28:0] quot_x25;
  logic [28:0] rem25_full;
  logic [7:0]  held_mod200;
  logic        in_window;
  logic        past_long;

  assign thr_prod  = {16'd0, cur_i.baseline} * {16'd0, cfg_i.threshold_factor};
  assign threshold = thr_prod[31:16];
  assign touched   = reading_i < threshold;
  assign cnt_inc   = cur_i.agree_count + 4'd1;
  assign flip      = (touched != cur_i.pressed) && (cnt_inc >= cfg_i.debounce_len);

  // hold time against the stored start; held mod 200 = 8 * ((held>>3) mod 25) + held[2:0]
  assign held       = now_ms_i - cur_i.press_start;
  assign held_div8  = held[31:3];
  assign recip_prod = 59'(held_div8) * 59'(tzq_pkg::RECIP_25);
  assign quot25     = recip_prod[58:tzq_pkg::RECIP_SHIFT];
  assign quot_x25   = 29'({quot25, 4'b0000}) + 29'({quot25, 3'b000}) + 29'(quot25);
  assign rem25_full = held_div8 - quot_x25;
  assign held_mod200 = {rem25_full[4:0], held[2:0]};
  assign in_window  = held_mod200 < tzq_pkg::REPEAT_WINDOW_MS;
  assign past_long  = held > {16'd0, cfg_i.hold_limit};

  always_comb begin
    nxt_o   = cur_i;
    event_o = '{emit: 1'b0, kind: tzq_pkg::KIND_RELEASE, held_ms: held};
    case (mode_i)
      tzq_pkg::MODE_CAL: begin
        nxt_o.baseline    = reading_i;
        nxt_o.pressed     = 1'b0;
        nxt_o.agree_count = '0;
        nxt_o.press_start = '0;
      end
      tzq_pkg::MODE_SAMPLE: begin
        if (touched != cur_i.pressed) begin
          if (flip) begin
            nxt_o.pressed     = touched;
            nxt_o.agree_count = '0;
            if (touched) begin
              nxt_o.press_start = now_ms_i;
            end else begin
              event_o.emit = 1'b1;
            end
          end else begin
            nxt_o.agree_count = cnt_inc;
          end
        end else begin
          nxt_o.agree_count = '0;
        end
        // still held from an earlier press
        if (cur_i.pressed && !flip && past_long && in_window) begin
          event_o.emit = 1'b1;
          event_o.kind = tzq_pkg::KIND_REPEAT;
        end
        if (!nxt_o.pressed && ({16'd0, reading_i} > {16'd0, cur_i.baseline})) begin
          nxt_o.baseline = cur_i.baseline + 16'd1;
        end
      end
      default: begin
        nxt_o = cur_i;
      end
    endcase
  end

endmodule

FILE: rtl/touch_zone_qualifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch zone qualifier
// Input beats: mode, zone, reading, now_ms on in_valid_i / in_stall_o.
// Result beats: event_zone, event_kind, held_ms, stamp_ms on out_valid_o /
// out_stall_i; a beat is taken when valid is high and stall is low.
// Each input beat gives zero or one result beat (release or long-press repeat).
// Pipeline: input register -> evaluator -> result register, with the zone
// state written on the same edge as the result. Throughput: one beat per
// cycle while in_stall_o is low.
// When the result register is full and stalled, the input register holds its
// beat and in_stall_o rises once it is occupied; one beat always fits ahead.
// Configuration: cfg_we_i writes cfg_wdata_i into the register cfg_index_i
// (0 threshold factor, 1 debounce count, 2 long-press time); write while idle.
// Reset (async, active low): zone state cleared, registers back to defaults,
// both stages empty. No clearing pass.
// ----------------------------------------------------------------------------
`include "touch_zone_qualifier_macros.svh"

module touch_zone_qualifier (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [tzq_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tzq_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // input beats
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           mode_i,
  input  logic [1:0]                     zone_i,
  input  logic [15:0]                    reading_i,
  input  logic [31:0]                    now_ms_i,
  // result beats
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     event_zone_o,
  output logic                           event_kind_o,
  output logic [31:0]                    held_ms_o,
  output logic [31:0]                    stamp_ms_o
);

  // configuration registers
  tzq_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{threshold_factor: tzq_pkg::THRESHOLD_RESET,
                 debounce_len:     tzq_pkg::DEBOUNCE_RESET,
                 hold_limit:       tzq_pkg::LONG_PRESS_RESET};
    end else if (cfg_we_i) begin
      case (tzq_pkg::cfg_idx_e'(cfg_index_i))
        tzq_pkg::CFG_THRESHOLD:  cfg_q.threshold_factor <= cfg_wdata_i;
        tzq_pkg::CFG_DEBOUNCE:   cfg_q.debounce_len     <= cfg_wdata_i[3:0];
        tzq_pkg::CFG_LONG_PRESS: cfg_q.hold_limit       <= cfg_wdata_i;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // handshake: the input stage drains whenever the result register can load
  logic in_accept;
  logic out_free;
  logic s1_fire;
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  // input register
  logic [0:0]  s1_mode_q;
  logic [1:0]  s1_zone_q;
  logic [15:0] s1_reading_q;
  logic [31:0] s1_now_q;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_mode_q    <= mode_i;
      s1_zone_q    <= zone_i;
      s1_reading_q <= reading_i;
      s1_now_q     <= now_ms_i;
    end
  end

  // zone state and evaluation
  logic                 zone_ok;
  tzq_pkg::zone_state_t cur_state;
  tzq_pkg::zone_state_t nxt_state;
  tzq_pkg::event_t      ev;
  logic                 emit;

  assign zone_ok = 32'(s1_zone_q) < tzq_pkg::ZONE_COUNT;
  assign emit    = s1_fire && zone_ok && ev.emit;

  tzq_zone_bank u_bank (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .zone_i    (s1_zone_q),
    .zone_ok_i (zone_ok),
    .wr_en_i   (s1_fire),
    .wr_data_i (nxt_state),
    .rd_data_o (cur_state)
  );

  tzq_eval u_eval (
    .mode_i    (tzq_pkg::mode_e'(s1_mode_q)),
    .reading_i (s1_reading_q),
    .now_ms_i  (s1_now_q),
    .cfg_i     (cfg_q),
    .cur_i     (cur_state),
    .nxt_o     (nxt_state),
    .event_o   (ev)
  );

  // result register
  logic [1:0]  res_zone_q;
  logic        res_kind_q;
  logic [31:0] res_held_q;
  logic [31:0] res_stamp_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_zone_q  <= s1_zone_q;
      res_kind_q  <= ev.kind;
      res_held_q  <= ev.held_ms;
      res_stamp_q <= s1_now_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_zone_o = res_zone_q;
  assign event_kind_o = res_kind_q;
  assign held_ms_o    = res_held_q;
  assign stamp_ms_o   = res_stamp_q;

  // checks
  logic ev_repeat;
  logic base_kept;

  assign ev_repeat = (ev.kind == tzq_pkg::KIND_REPEAT);
  assign base_kept = (nxt_state.baseline == cur_state.baseline);

  `TZQ_ASSERT(a_stall_needs_beat, in_stall_o |-> s1_valid_q, "stall with empty input stage")
  `TZQ_ASSERT(a_result_from_fire, $rose(out_valid_q) |-> $past(s1_fire), "result without a beat")
  `TZQ_ASSERT(a_event_vs_state, emit |-> (nxt_state.pressed == ev_repeat), "event kind vs state")
  `TZQ_ASSERT(a_no_drift_pressed, (s1_fire && nxt_state.pressed) |-> base_kept, "drift when pressed")
  `TZQ_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> (!out_valid_o && !in_stall_o), "busy in reset")

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch zone qualifier testbench
// Self-checking bench: a behavioural copy of the zone state predicts each
// release and long-press repeat event. Directed gestures and register
// extremes come first, then random gestures and noise over several register
// settings. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned CLK_HALF_NS   = 10;
  localparam int unsigned RESET_CYCLES  = 9;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned RANDOM_ITEMS  = 800;
  localparam int unsigned PHASE_ITEMS   = 100;
  localparam int unsigned MAX_GAP       = 13;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam logic [31:0] REPEAT_PERIOD_MS = 32'd200;
  // index with no register behind it; writes must leave everything alone
  localparam logic [tzq_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0]     zone;
    tzq_pkg::kind_e kind;
    logic [31:0]    held_ms;
    logic [31:0]    stamp_ms;
  } zone_beat_t;

  // --------------------------------------------------------------------------
  // DUT connections; every input has a known value from time zero
  // --------------------------------------------------------------------------
  logic                           clk_i     = 1'b0;
  logic                           rst_ni    = 1'b0;
  logic                           cfg_we    = 1'b0;
  logic [tzq_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [tzq_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  tzq_pkg::mode_e                 mode      = tzq_pkg::MODE_SAMPLE;
  logic [1:0]                     zone      = '0;
  logic [15:0]                    reading   = '0;
  logic [31:0]                    now_ms    = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [1:0]                     event_zone;
  logic                           event_kind;
  logic [31:0]                    held_ms;
  logic [31:0]                    stamp_ms;

  touch_zone_qualifier dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .mode_i       (mode),
    .zone_i       (zone),
    .reading_i    (reading),
    .now_ms_i     (now_ms),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .event_zone_o (event_zone),
    .event_kind_o (event_kind),
    .held_ms_o    (held_ms),
    .stamp_ms_o   (stamp_ms)
  );

  always #(CLK_HALF_NS) clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Predicted copy of the registers and the per-zone state
  // --------------------------------------------------------------------------
  logic [15:0] thr_factor;
  logic [3:0]  debounce_n;
  logic [15:0] long_press;
  logic [15:0] baseline    [tzq_pkg::ZONE_COUNT];
  logic        pressed     [tzq_pkg::ZONE_COUNT];
  logic [3:0]  agree_cnt   [tzq_pkg::ZONE_COUNT];
  logic [31:0] press_start [tzq_pkg::ZONE_COUNT];

  zone_beat_t pending_events[$];   // predicted events not yet seen

  int unsigned mismatches  = 0;
  int unsigned items_sent  = 0;
  int unsigned cycle_count = 0;
  bit          in_calm     = 1'b0;   // sender idles between beats unless set
  bit          out_calm    = 1'b0;   // receiver stalls between beats unless set
  logic [31:0] clock_ms    = '0;     // running time base for gestures

  // touch threshold: truncated Q0.16 product, always fits 16 bits
  function automatic logic [15:0] touch_threshold(logic [1:0] z);
    logic [31:0] product;
    product = 32'(baseline[z]) * 32'(thr_factor);
    return product[31:16];
  endfunction

  // Advance the zone state by one accepted beat and queue any event it causes.
  function automatic void qualify_reading(tzq_pkg::mode_e m, logic [1:0] z,
                                          logic [15:0] r, logic [31:0] t);
    logic        touched;
    logic [3:0]  next_count;
    logic [31:0] held;
    if (m == tzq_pkg::MODE_CAL) begin
      baseline[z]    = r;
      pressed[z]     = 1'b0;
      agree_cnt[z]   = '0;
      press_start[z] = '0;
      return;
    end
    touched = r < touch_threshold(z);
    if (touched != pressed[z]) begin
      next_count = agree_cnt[z] + 4'd1;   // 4-bit wrap is intended
      if (next_count >= debounce_n) begin
        pressed[z]   = touched;
        agree_cnt[z] = '0;
        if (touched) begin
          press_start[z] = t;
        end else begin
          pending_events.push_back('{z, tzq_pkg::KIND_RELEASE, t - press_start[z], t});
        end
      end else begin
        agree_cnt[z] = next_count;
      end
    end else begin
      agree_cnt[z] = '0;
    end
    // a release leaves the zone unpressed, so no repeat on the same beat
    held = t - press_start[z];
    if (pressed[z] && held > 32'(long_press) &&
        held % REPEAT_PERIOD_MS < 32'(tzq_pkg::REPEAT_WINDOW_MS)) begin
      pending_events.push_back('{z, tzq_pkg::KIND_REPEAT, held, t});
    end
    // baseline creeps up only while untouched; 65535 can never be exceeded
    if (!pressed[z] && r > baseline[z]) begin
      baseline[z] = baseline[z] + 16'd1;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // One input beat. Valid is only dropped when a gap is drawn, so back-to-back
  // beats never see valid lowered and raised in the same step.
  task automatic send_item(tzq_pkg::mode_e m, logic [1:0] z, logic [15:0] r,
                           logic [31:0] t);
    int unsigned gap;
    gap = in_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    mode     <= m;
    zone     <= z;
    reading  <= r;
    now_ms   <= t;
    do @(posedge clk_i); while (in_stall !== 1'b0);
    qualify_reading(m, z, r, t);
    items_sent++;
  endtask

  task automatic write_reg(logic [tzq_pkg::CFG_IDX_W-1:0] idx,
                           logic [tzq_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      tzq_pkg::CFG_THRESHOLD:  thr_factor = data;
      tzq_pkg::CFG_DEBOUNCE:   debounce_n = data[3:0];
      tzq_pkg::CFG_LONG_PRESS: long_press = data;
      default: ;
    endcase
  endtask

  // Quiet the input side and let every predicted event drain; the settle
  // covers a last beat that produced nothing but is still in flight.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall per beat, then compare with the oldest event
  // --------------------------------------------------------------------------
  initial begin : event_monitor
    int unsigned hold;
    zone_beat_t  got;
    zone_beat_t  want;
    forever begin
      hold = out_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (out_valid !== 1'b1);
      got = '{event_zone, tzq_pkg::kind_e'(event_kind), held_ms, stamp_ms};
      if (pending_events.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("unexpected event: zone %0d kind %0d held %0d stamp %0d",
                   got.zone, got.kind, got.held_ms, got.stamp_ms);
        end
      end else begin
        want = pending_events.pop_front();
        if (got.zone !== want.zone || got.kind !== want.kind ||
            got.held_ms !== want.held_ms || got.stamp_ms !== want.stamp_ms) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("event mismatch: expected zone %0d kind %0d held %0d stamp %0d",
                     want.zone, want.kind, want.held_ms, want.stamp_ms);
            $display("                got      zone %0d kind %0d held %0d stamp %0d",
                     got.zone, got.kind, got.held_ms, got.stamp_ms);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Random stimulus helpers
  // --------------------------------------------------------------------------
  // register value: the bounds now and then, otherwise anywhere in range
  function automatic logic [15:0] pick_level(logic [15:0] top);
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return top;
      default: return 16'($urandom_range(0, top));
    endcase
  endfunction

  // reading on the requested side of the threshold, often right at the edge
  function automatic logic [15:0] pick_reading(logic [1:0] z, bit touch);
    logic [15:0] thresh;
    thresh = touch_threshold(z);
    if (touch && thresh != 0) begin
      return ($urandom_range(0, 3) == 0) ? thresh - 16'd1
                                         : 16'($urandom_range(0, thresh - 1));
    end
    return ($urandom_range(0, 3) == 0) ? thresh : 16'($urandom_range(thresh, 65535));
  endfunction

  // timestamp relative to the press: long-press boundary, repeat windows,
  // plain spread, or anything at all (wrap)
  function automatic logic [31:0] pick_hold_stamp(logic [1:0] z);
    logic [31:0] held;
    case ($urandom_range(0, 3))
      0:       held = $urandom_range(0, 70000);
      1:       held = 32'(long_press) + $urandom_range(0, 2);
      2:       held = (32'(long_press) / REPEAT_PERIOD_MS + $urandom_range(0, 3))
                      * REPEAT_PERIOD_MS + $urandom_range(0, 24);
      default: held = $urandom();
    endcase
    return press_start[z] + held;
  endfunction

  // press, hold, lift on one zone; short runs and stray readings break some
  task automatic play_gesture(logic [1:0] z);
    int unsigned presses;
    int unsigned holds;
    int unsigned lifts;
    if ($urandom_range(0, 3) == 0 || touch_threshold(z) == 0) begin
      clock_ms += $urandom_range(1, 50);
      send_item(tzq_pkg::MODE_CAL, z, 16'($urandom_range(1000, 65535)), clock_ms);
    end
    presses = ($urandom_range(0, 4) == 0) ? $urandom_range(0, debounce_n)
                                          : debounce_n + $urandom_range(0, 1);
    repeat (presses) begin
      clock_ms += $urandom_range(1, 40);
      send_item(tzq_pkg::MODE_SAMPLE, z, pick_reading(z, $urandom_range(0, 7) != 0),
                clock_ms);
    end
    holds = $urandom_range(0, 10);
    repeat (holds) begin
      clock_ms = pick_hold_stamp(z);
      send_item(tzq_pkg::MODE_SAMPLE, z, pick_reading(z, 1'b1), clock_ms);
    end
    lifts = debounce_n + $urandom_range(0, 1);
    repeat (lifts) begin
      clock_ms = pick_hold_stamp(z);
      send_item(tzq_pkg::MODE_SAMPLE, z, pick_reading(z, $urandom_range(0, 7) == 0),
                clock_ms);
    end
  endtask

  task automatic send_noise();
    tzq_pkg::mode_e m;
    m = ($urandom_range(0, 7) == 0) ? tzq_pkg::MODE_CAL : tzq_pkg::MODE_SAMPLE;
    clock_ms = ($urandom_range(0, 3) == 0) ? $urandom() : clock_ms + $urandom_range(0, 300);
    send_item(m, 2'($urandom_range(0, tzq_pkg::ZONE_COUNT - 1)), 16'($urandom()),
              clock_ms);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset defaults: threshold 649 on a baseline of 1000, debounce of two,
  // a repeat across wrapped time, zero baseline and baseline creep.
  task automatic test_default_gestures();
    send_item(tzq_pkg::MODE_CAL,    2'd0, 16'd1000,  32'd0);
    send_item(tzq_pkg::MODE_SAMPLE, 2'd0, 16'd600,   32'd100);  // first disagreeing read
    send_item(tzq_pkg::MODE_SAMPLE, 2'd0, 16'd700,   32'd110);  // agreement clears count
    send_item(tzq_pkg::MODE_SAMPLE, 2'd0, 16'd600,   32'd120);
    send_item(tzq_pkg::MODE_SAMPLE, 2'd0, 16'd649,   32'd130);  // at threshold: untouched, count cleared
    send_item(tzq_pkg::MODE_SAMPLE, 2'd0, 16'd0,     32'd730);  // first touching read
    send_item(tzq_pkg::MODE_SAMPLE, 2'd0, 16'd100,   32'd749);  // second touching read: press
    send_item(tzq_pkg::MODE_SAMPLE, 2'd0, 16'd100,   32'd750);  // held 1: no event
    send_item(tzq_pkg::MODE_SAMPLE, 2'd0, 16'd650,   32'd830);  // above threshold: untouched
    send_item(tzq_pkg::MODE_SAMPLE, 2'd0, 16'd65535, 32'd930);  // release, then creep
    send_item(tzq_pkg::MODE_CAL,    2'd1, 16'd65535, 32'hFFFF_FF00);
    send_item(tzq_pkg::MODE_SAMPLE, 2'd1, 16'd0,     32'hFFFF_FF10);
    send_item(tzq_pkg::MODE_SAMPLE, 2'd1, 16'd0,     32'hFFFF_FF20);
    send_item(tzq_pkg::MODE_SAMPLE, 2'd1, 16'd0,     32'd576);  // held 800 across wrap
    send_item(tzq_pkg::MODE_SAMPLE, 2'd1, 16'd65535, 32'hFFFF_FFFF);
    send_item(tzq_pkg::MODE_SAMPLE, 2'd1, 16'd65535, 32'd600);  // release across wrap
    send_item(tzq_pkg::MODE_CAL,    2'd2, 16'd0,     32'd5);    // zero baseline
    send_item(tzq_pkg::MODE_SAMPLE, 2'd2, 16'd0,     32'd6);
    send_item(tzq_pkg::MODE_SAMPLE, 2'd2, 16'd65535, 32'd7);    // creeps to one
    send_item(tzq_pkg::MODE_SAMPLE, 2'd2, 16'd1,     32'd8);    // equal: no creep
    send_item(tzq_pkg::MODE_CAL,    2'd3, 16'd65535, 32'd9);
    send_item(tzq_pkg::MODE_SAMPLE, 2'd3, 16'd65535, 32'd10);   // full baseline stays put
  endtask

  // Register bounds, the unmapped index, and a debounce of zero.
  task automatic test_register_extremes();
    wait_idle();
    write_reg(tzq_pkg::CFG_THRESHOLD,  16'hFFFF);
    write_reg(tzq_pkg::CFG_DEBOUNCE,   16'd1);
    write_reg(tzq_pkg::CFG_LONG_PRESS, 16'd0);
    write_reg(CFG_SPARE,               16'hFFFF);
    send_item(tzq_pkg::MODE_CAL,    2'd0, 16'd65535, 32'd1000);
    send_item(tzq_pkg::MODE_SAMPLE, 2'd0, 16'd65533, 32'd1000); // threshold 65534: press
    send_item(tzq_pkg::MODE_SAMPLE, 2'd0, 16'd65533, 32'd1001); // held 1 > 0: repeat
    send_item(tzq_pkg::MODE_SAMPLE, 2'd0, 16'd65534, 32'd1020); // release
    wait_idle();
    write_reg(tzq_pkg::CFG_THRESHOLD,  16'h0000);
    write_reg(tzq_pkg::CFG_DEBOUNCE,   16'hFFFF);               // upper bits dropped: 15
    write_reg(tzq_pkg::CFG_LONG_PRESS, 16'hFFFF);
    send_item(tzq_pkg::MODE_CAL,    2'd3, 16'd100,   32'd2000);
    send_item(tzq_pkg::MODE_SAMPLE, 2'd3, 16'd0,     32'd2001); // zero threshold: untouched
    send_item(tzq_pkg::MODE_SAMPLE, 2'd3, 16'd65535, 32'd2002);
    wait_idle();
    write_reg(tzq_pkg::CFG_THRESHOLD, tzq_pkg::THRESHOLD_RESET);
    write_reg(tzq_pkg::CFG_DEBOUNCE,  16'd0);                   // every disagreement flips
    send_item(tzq_pkg::MODE_CAL,    2'd1, 16'd1000,  32'd3000);
    send_item(tzq_pkg::MODE_SAMPLE, 2'd1, 16'd0,     32'd3001);
    send_item(tzq_pkg::MODE_SAMPLE, 2'd1, 16'd65535, 32'd3050);
  endtask

  // Phases of random gestures and noise, each under a fresh register setting
  // and its own idling style.
  task automatic test_random_phases();
    int unsigned random_goal;
    int unsigned phase_goal;
    random_goal = items_sent + RANDOM_ITEMS;
    while (items_sent < random_goal) begin
      wait_idle();
      write_reg(tzq_pkg::CFG_THRESHOLD,  pick_level(16'hFFFF));
      write_reg(tzq_pkg::CFG_DEBOUNCE,   (16'($urandom()) & 16'hFFF0) | pick_level(16'd15));
      write_reg(tzq_pkg::CFG_LONG_PRESS, pick_level(16'hFFFF));
      in_calm    = ($urandom_range(0, 3) == 0);
      out_calm   = ($urandom_range(0, 3) == 0);
      phase_goal = items_sent + PHASE_ITEMS;
      while (items_sent < phase_goal) begin
        if ($urandom_range(0, 9) < 7) begin
          play_gesture(2'($urandom_range(0, tzq_pkg::ZONE_COUNT - 1)));
        end else begin
          repeat ($urandom_range(1, 4)) send_noise();
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    thr_factor = tzq_pkg::THRESHOLD_RESET;
    debounce_n = tzq_pkg::DEBOUNCE_RESET;
    long_press = tzq_pkg::LONG_PRESS_RESET;
    for (int i = 0; i < tzq_pkg::ZONE_COUNT; i++) begin
      baseline[i]    = '0;
      pressed[i]     = 1'b0;
      agree_cnt[i]   = '0;
      press_start[i] = '0;
    end
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_default_gestures();
    test_register_extremes();
    test_random_phases();
    wait_idle();
    // room for a stray event held back by the longest stall
    repeat (2 * MAX_GAP) @(posedge clk_i);
    if (mismatches == 0 && pending_events.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

endmodule
